>>> hw/rtl/cau_pkg.sv
`timescale 1ns / 1ps

package cau_pkg;

   // Operation codes carried in the mode field of a request beat.
   localparam logic [2:0] ModeAdd = 3'd0;
   localparam logic [2:0] ModeSub = 3'd1;
   localparam logic [2:0] ModeMul = 3'd2;
   localparam logic [2:0] ModeDiv = 3'd3;
   localparam logic [2:0] ModeExp = 3'd4;
   localparam logic [2:0] ModeMag = 3'd5;

   // Fixed-point constants in Q2.30 (36-bit signed unless noted).
   localparam logic signed [35:0] KinvQ30   = 36'sd652032874;
   localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
   localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
   localparam logic signed [35:0] TwoPiQ30  = 36'sd6746518852;
   localparam logic signed [35:0] Ln2Q30    = 36'sd744261118;

   // Reciprocal of ln2 for the first estimate of the exponent:
   // k is about (a_re * KRecip) >> KRecipShift.
   localparam logic signed [17:0] KRecip      = 18'sd94547;
   localparam int                 KRecipShift = 28;

   // Length of the angle and logarithm tables.
   localparam int TblLen = 32;

   // Number of quotient bits that the divider produces, one per stage.
   localparam int DivBits = 48;

   // Arctangent of 2^-i in Q2.30.
   localparam logic [29:0] AtanTab [TblLen] = '{
      30'd843314857, 30'd497837830, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
      30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
      30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
      30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
   };

   // Natural logarithm of 1 + 2^-i in Q2.30.
   localparam logic [29:0] LnTab [TblLen] = '{
      30'd744261118, 30'd435364845, 30'd239598564, 30'd126468572, 30'd65095192,
      30'd33040817, 30'd16647494, 30'd8356010, 30'd4186133, 30'd2095107,
      30'd1048064, 30'd524160, 30'd262112, 30'd131064, 30'd65534, 30'd32768,
      30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
      30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
   };

   // Request beat: operation and two complex operands in Q3.12.
   typedef struct packed {
      logic [2:0]         mode;
      logic signed [15:0] a_re;
      logic signed [15:0] a_im;
      logic signed [15:0] b_re;
      logic signed [15:0] b_im;
   } req_type;

   // Response beat: complex result in Q15.16 and status flags.
   typedef struct packed {
      logic signed [31:0] res_re;
      logic signed [31:0] res_im;
      logic               div_zero;
      logic               saturated;
   } rsp_type;

endpackage

>>> hw/rtl/complex_arithmetic_unit.sv
`timescale 1ns / 1ps

// Complex arithmetic unit.
// A request beat carries a mode and two complex operands a and b in Q3.12; each
// request gives exactly one response beat with a Q15.16 result and two flags.
// Modes are add, subtract, multiply, divide, exp(a) and |a|.
// Every request runs through the same pipeline of DivBits + 6 register stages,
// whatever the mode; the 48-stage restoring divider sets that figure, and the
// CORDIC and exponent stages run alongside it.
// One request is taken in every cycle unless req_stall is raised, so the throughput is one beat per cycle.
// Results leave in the order the requests came in.
// When the receiver stalls while a response waits, the whole pipeline holds and
// req_stall is raised in the same cycle; nothing is lost or repeated.
// A synchronous reset clears every valid bit; the payload registers are left as
// they are. There is no clearing pass and no configuration port.
// Divide by zero gives a zero result with div_zero set; results outside the
// 32-bit range are clipped and saturated is set.
module complex_arithmetic_unit
   import cau_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int CoreStages = (DivBits > CORDIC_STAGES) ? DivBits : CORDIC_STAGES;
   localparam int NumPipe    = CoreStages + 5;

   // Working state that travels with each item through the pipeline.
   typedef struct packed {
      logic [2:0]         mode;
      logic signed [15:0] ar;
      logic signed [15:0] ai;
      logic signed [31:0] prr;
      logic signed [31:0] pii;
      logic signed [31:0] pri;
      logic signed [31:0] pir;
      logic signed [31:0] pbr;
      logic signed [31:0] pbi;
      logic signed [31:0] sr;
      logic signed [31:0] si;
      logic signed [4:0]  k;
      logic signed [32:0] r;
      logic [31:0]        e;
      logic               flip;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic [31:0]        d;
      logic [47:0]        n_re;
      logic [47:0]        n_im;
      logic               sg_re;
      logic               sg_im;
      logic [31:0]        rem_re;
      logic [31:0]        rem_im;
      logic signed [63:0] p1;
      logic signed [63:0] p2;
   } pipe_type;

   pipe_type pipe_in [NumPipe];
   pipe_type pipe_ff [NumPipe];
   logic [NumPipe-1:0] valid_ff;
   rsp_type rsp_in;
   rsp_type rsp_payload_ff;
   logic    rsp_valid_ff;
   logic    advance;

   // Round to nearest (half up) after an arithmetic shift, then clip to 32 bits.
   function automatic logic [32:0] round_sat(input logic signed [63:0] p,
                                             input logic [5:0] sh);
      logic signed [65:0] v;
      logic [65:0]        bias;
      logic               sat;
      logic [31:0]        val;
      bias = 66'd1 << (sh - 6'd1);
      v    = $signed({{2{p[63]}}, p}) + $signed(bias);
      v    = v >>> sh;
      sat  = ~(&v[65:31]) && (|v[65:31]);
      if (sat) begin
         val = v[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         val = v[31:0];
      end
      return {sat, val};
   endfunction

   // Apply the sign to an unsigned quotient and clip to 32 bits.
   function automatic logic [32:0] div_sat(input logic [47:0] q, input logic neg);
      logic        sat;
      logic [31:0] val;
      if (neg) begin
         sat = (|q[47:32]) || (q[31] && (|q[30:0]));
         val = sat ? 32'h8000_0000 : (~q[31:0] + 32'd1);
      end else begin
         sat = |q[47:31];
         val = sat ? 32'h7FFF_FFFF : q[31:0];
      end
      return {sat, val};
   endfunction

   // The whole pipeline moves unless a finished response is held up.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // First stage: operand products, add and subtract, first exponent estimate.
   always_comb begin
      pipe_type           st;
      logic signed [16:0] sum_re;
      logic signed [16:0] sum_im;
      logic signed [33:0] kp;
      st      = '0;
      st.mode = req_payload.mode;
      st.ar   = req_payload.a_re;
      st.ai   = req_payload.a_im;
      st.prr  = req_payload.a_re * req_payload.b_re;
      st.pii  = req_payload.a_im * req_payload.b_im;
      st.pri  = req_payload.a_re * req_payload.b_im;
      st.pir  = req_payload.a_im * req_payload.b_re;
      st.pbr  = req_payload.b_re * req_payload.b_re;
      st.pbi  = req_payload.b_im * req_payload.b_im;
      if (req_payload.mode == ModeSub) begin
         sum_re = 17'(req_payload.a_re) - 17'(req_payload.b_re);
         sum_im = 17'(req_payload.a_im) - 17'(req_payload.b_im);
      end else begin
         sum_re = 17'(req_payload.a_re) + 17'(req_payload.b_re);
         sum_im = 17'(req_payload.a_im) + 17'(req_payload.b_im);
      end
      if (req_payload.mode == ModeAdd || req_payload.mode == ModeSub) begin
         st.sr = {{11{sum_re[16]}}, sum_re, 4'b0};
         st.si = {{11{sum_im[16]}}, sum_im, 4'b0};
      end
      kp   = req_payload.a_re * KRecip;
      st.k = kp[KRecipShift+4:KRecipShift];
      pipe_in[0] = st;
   end

   // Second stage: product sums, divisor, exponent remainder, first angle wrap.
   always_comb begin
      pipe_type           st;
      logic signed [33:0] t_re;
      logic signed [33:0] t_im;
      logic signed [33:0] s_re;
      logic signed [33:0] s_im;
      logic signed [32:0] nre;
      logic signed [32:0] nim;
      logic signed [35:0] xv;
      logic signed [35:0] kl;
      logic signed [35:0] rd;
      logic signed [35:0] th;
      st   = pipe_ff[0];
      t_re = 34'(st.prr) - 34'(st.pii) + 34'sd128;
      t_im = 34'(st.pri) + 34'(st.pir) + 34'sd128;
      s_re = t_re >>> 8;
      s_im = t_im >>> 8;
      if (st.mode == ModeMul) begin
         st.sr = s_re[31:0];
         st.si = s_im[31:0];
      end
      nre     = 33'(st.prr) + 33'(st.pii);
      nim     = 33'(st.pir) - 33'(st.pri);
      st.n_re = {{15{nre[32]}}, nre};
      st.n_im = {{15{nim[32]}}, nim};
      st.d    = $unsigned(st.pbr) + $unsigned(st.pbi);
      xv      = {{2{st.ar[15]}}, st.ar, 18'b0};
      kl      = st.k * Ln2Q30;
      rd      = xv - kl;
      st.r    = rd[32:0];
      th      = {{2{st.ai[15]}}, st.ai, 18'b0};
      if (th > PiQ30) begin
         th = th - TwoPiQ30;
      end else if (th < -PiQ30) begin
         th = th + TwoPiQ30;
      end
      st.z = th[33:0];
      pipe_in[1] = st;
   end

   // Third stage: exponent correction, half-plane fold, CORDIC and divider start.
   always_comb begin
      pipe_type           st;
      logic signed [32:0] mre;
      logic signed [32:0] mim;
      logic signed [16:0] abs_ar;
      st = pipe_ff[1];
      if (st.r < 33'sd0) begin
         st.r = st.r + 33'(Ln2Q30);
         st.k = st.k - 5'sd1;
      end else if (st.r >= 33'(Ln2Q30)) begin
         st.r = st.r - 33'(Ln2Q30);
         st.k = st.k + 5'sd1;
      end
      st.flip = 1'b0;
      if (st.z > 34'(HalfPiQ30)) begin
         st.z    = st.z - 34'(PiQ30);
         st.flip = 1'b1;
      end else if (st.z < -34'(HalfPiQ30)) begin
         st.z    = st.z + 34'(PiQ30);
         st.flip = 1'b1;
      end
      st.e   = 32'd1 << 30;
      abs_ar = st.ar[15] ? -17'(st.ar) : 17'(st.ar);
      if (st.mode == ModeMag) begin
         st.x = {3'b0, abs_ar, 14'b0};
         st.y = {{4{st.ai[15]}}, st.ai, 14'b0};
      end else begin
         st.x = 34'(KinvQ30);
         st.y = '0;
      end
      mre       = st.n_re[32:0];
      mim       = st.n_im[32:0];
      st.sg_re  = mre[32];
      st.sg_im  = mim[32];
      mre       = st.sg_re ? -mre : mre;
      mim       = st.sg_im ? -mim : mim;
      st.n_re   = {mre[31:0], 16'b0} + {17'b0, st.d[31:1]};
      st.n_im   = {mim[31:0], 16'b0} + {17'b0, st.d[31:1]};
      st.rem_re = '0;
      st.rem_im = '0;
      pipe_in[2] = st;
   end

   // Core stages: one quotient bit each, and one CORDIC and exponent step in
   // each of the first CORDIC_STAGES of them.
   for (genvar j = 0; j < CoreStages; j++) begin : g_core
      localparam int Ti = j % TblLen;
      always_comb begin
         pipe_type    st;
         logic        dirn;
         logic [32:0] rs_re;
         logic [32:0] rs_im;
         logic        qb_re;
         logic        qb_im;
         logic signed [33:0] xs;
         logic signed [33:0] ys;
         st   = pipe_ff[j+2];
         xs   = '0;
         ys   = '0;
         dirn = 1'b0;
         if (j < CORDIC_STAGES) begin
            xs   = st.x >>> j;
            ys   = st.y >>> j;
            dirn = (st.mode == ModeMag) ? st.y[33] : ~st.z[33];
            if (dirn) begin
               st.x = st.x - ys;
               st.y = st.y + xs;
               st.z = st.z - $signed({4'b0, AtanTab[Ti]});
            end else begin
               st.x = st.x + ys;
               st.y = st.y - xs;
               st.z = st.z + $signed({4'b0, AtanTab[Ti]});
            end
            if (st.r >= $signed({3'b0, LnTab[Ti]})) begin
               st.r = st.r - $signed({3'b0, LnTab[Ti]});
               st.e = st.e + (st.e >> j);
            end
         end
         // Restoring division step for both parts against the shared divisor.
         rs_re = {st.rem_re, st.n_re[47]};
         rs_im = {st.rem_im, st.n_im[47]};
         qb_re = rs_re >= {1'b0, st.d};
         qb_im = rs_im >= {1'b0, st.d};
         if (qb_re) begin
            rs_re = rs_re - {1'b0, st.d};
         end
         if (qb_im) begin
            rs_im = rs_im - {1'b0, st.d};
         end
         st.rem_re = rs_re[31:0];
         st.rem_im = rs_im[31:0];
         st.n_re   = {st.n_re[46:0], qb_re};
         st.n_im   = {st.n_im[46:0], qb_im};
         pipe_in[j+3] = st;
      end
   end

   // Undo the half-plane fold on the rotated vector.
   always_comb begin
      pipe_type st;
      st = pipe_ff[CoreStages+2];
      if (st.flip && st.mode == ModeExp) begin
         st.x = -st.x;
         st.y = -st.y;
      end
      pipe_in[CoreStages+3] = st;
   end

   // Product stage: exp(re) times cos and sin, or the CORDIC gain correction.
   always_comb begin
      pipe_type           st;
      logic signed [31:0] opa;
      logic signed [31:0] opb;
      st = pipe_ff[CoreStages+3];
      if (st.mode == ModeMag) begin
         opa = st.x[31:0];
         opb = KinvQ30[31:0];
      end else begin
         opa = $signed(st.e);
         opb = st.x[31:0];
      end
      st.p1 = opa * opb;
      st.p2 = $signed(st.e) * $signed(st.y[31:0]);
      pipe_in[CoreStages+4] = st;
   end

   // Output stage: rounding, clipping and selection by mode.
   always_comb begin
      pipe_type          st;
      logic [32:0]       v_re;
      logic [32:0]       v_im;
      logic signed [6:0] shw;
      st   = pipe_ff[NumPipe-1];
      shw  = 7'sd44 - 7'(st.k);
      v_re = '0;
      v_im = '0;
      rsp_in = '0;
      case (st.mode)
         ModeAdd, ModeSub, ModeMul: begin
            rsp_in.res_re = st.sr;
            rsp_in.res_im = st.si;
         end
         ModeDiv: begin
            if (st.d == 32'd0) begin
               rsp_in.div_zero = 1'b1;
            end else begin
               v_re = div_sat(st.n_re, st.sg_re);
               v_im = div_sat(st.n_im, st.sg_im);
               rsp_in.res_re    = v_re[31:0];
               rsp_in.res_im    = v_im[31:0];
               rsp_in.saturated = v_re[32] | v_im[32];
            end
         end
         ModeExp: begin
            v_re = round_sat(st.p1, shw[5:0]);
            v_im = round_sat(st.p2, shw[5:0]);
            rsp_in.res_re    = v_re[31:0];
            rsp_in.res_im    = v_im[31:0];
            rsp_in.saturated = v_re[32] | v_im[32];
         end
         ModeMag: begin
            v_re = round_sat(st.p1, 6'd40);
            rsp_in.res_re    = v_re[31:0];
            rsp_in.saturated = v_re[32];
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // Pipeline registers; valid bits move with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[NumPipe-2:0], req_valid};
         rsp_valid_ff <= valid_ff[NumPipe-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NumPipe; i++) begin
            pipe_ff[i] <= pipe_in[i];
         end
         rsp_payload_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The input is held back only while a finished response is stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled response");

   // A zero divisor forces a zero, unclipped result.
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.div_zero) |->
         (rsp_payload.res_re == 32'sd0 && rsp_payload.res_im == 32'sd0
          && !rsp_payload.saturated))
      else $error("divide-by-zero response is not zero");

   // Nothing leaves in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   // A stalled response is not replaced by the next item in the pipeline.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");

endmodule
